// ===== rtl/upfp_pkg.sv =====
// upfp_pkg: types and constants shared by the ping-pong frame packetizer
// used by upfp_front, upfp_queue, upfp_back and the top level
// no dependencies
`default_nettype none

package upfp_pkg;

   localparam int unsigned SIZE_W = 20;
   localparam int unsigned LEN_W  = 10;

   // frame sizes above this are stored as this
   localparam logic [SIZE_W:0] MAX_FRAME_BYTES = 21'd524288;

   localparam logic [LEN_W-1:0] PACKET_BYTES_RESET = 10'd1023;
   localparam logic [LEN_W-1:0] MIN_PACKET_BYTES   = 10'd3;
   localparam logic [LEN_W-1:0] HDR_BYTES          = 10'd2;

   // header flag bit positions
   localparam int unsigned FLAG_FID = 0;
   localparam int unsigned FLAG_EOF = 1;

   localparam logic [1:0] PREFILL_DONE = 2'd2;

   typedef enum logic {
      KIND_FRAME_DONE = 1'b0,
      KIND_PACKET_REQ = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [SIZE_W-1:0] size;
   } item_type;

   typedef struct packed {
      logic              endpoint_half;
      logic              buffer_sel;
      logic [SIZE_W-1:0] frame_offset;
      logic [LEN_W-1:0]  payload_len;
      logic [1:0]        header_flags;
      logic              packet_valid;
      logic              frame_accepted;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/upfp_front.sv =====
// upfp_front: classifies an incoming word and clamps the frame size
// depends on upfp_pkg
`default_nettype none

module upfp_front
   import upfp_pkg::*;
(
   input  wire logic              req_kind,
   input  wire logic [SIZE_W-1:0] req_frame_bytes,
   output item_type               item
);

   logic [SIZE_W-1:0] clamped;

   always_comb begin
      if ({1'b0, req_frame_bytes} > MAX_FRAME_BYTES) begin
         clamped = MAX_FRAME_BYTES[SIZE_W-1:0];
      end else begin
         clamped = req_frame_bytes;
      end
      item.kind = kind_type'(req_kind);
      // size only matters for frame-done words
      item.size = (req_kind == KIND_FRAME_DONE) ? clamped : '0;
   end

endmodule

`default_nettype wire

// ===== rtl/upfp_queue.sv =====
// upfp_queue: small first-in first-out queue between front and back
// depends on upfp_pkg
`default_nettype none

module upfp_queue
   import upfp_pkg::*;
#(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          full,
   input  wire logic     pop,
   output logic          not_empty,
   output item_type      head_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   item_type         entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == DEPTH_CNT);
   assign not_empty = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/upfp_back.sv =====
// upfp_back: buffer bookkeeping, packet cutting and the result register
// depends on upfp_pkg
`default_nettype none

module upfp_back
   import upfp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   input  wire logic [LEN_W-1:0] csr_wdata,
   input  wire logic             q_not_empty,
   input  wire item_type         q_item,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp
);

   logic [LEN_W-1:0]  cap_ff, cap_in;
   logic              rb_ff, rb_in;
   logic              wb_ff, wb_in;
   logic [SIZE_W-1:0] stored_ff [2];
   logic [SIZE_W-1:0] stored_in [2];
   logic [SIZE_W-1:0] sent_ff, sent_in;
   logic [1:0]        flag_ff, flag_in;
   logic              half_ff, half_in;
   logic [1:0]        prefill_ff, prefill_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;
   rsp_type           result;

   logic              fire;
   logic [SIZE_W-1:0] cur_size;
   logic [1:0]        flag_cur;
   logic [SIZE_W:0]   span;
   logic              frame_end;
   logic [SIZE_W-1:0] remain;
   logic [LEN_W-1:0]  len;

   assign fire      = q_not_empty && (!rsp_valid_ff || rsp_ready);
   assign q_pop     = fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      cap_in = cap_ff;
      if (csr_valid) begin
         cap_in = (csr_wdata < MIN_PACKET_BYTES) ? (MIN_PACKET_BYTES - HDR_BYTES)
                                                 : (csr_wdata - HDR_BYTES);
      end
   end

   always_comb begin
      rb_in        = rb_ff;
      wb_in        = wb_ff;
      stored_in[0] = stored_ff[0];
      stored_in[1] = stored_ff[1];
      sent_in      = sent_ff;
      flag_in      = flag_ff;
      half_in      = half_ff;
      prefill_in   = prefill_ff;
      result       = '0;

      cur_size  = stored_ff[rb_ff];
      // a new frame starts when nothing of it has gone out yet
      flag_cur  = (sent_ff == '0) ? {1'b0, ~flag_ff[FLAG_FID]} : flag_ff;
      span      = {1'b0, sent_ff} + {{(SIZE_W + 1 - LEN_W){1'b0}}, cap_ff};
      frame_end = (span >= {1'b0, cur_size});
      remain    = cur_size - sent_ff;
      if (sent_ff >= cur_size) begin
         len = '0;
      end else if (frame_end) begin
         len = remain[LEN_W-1:0];
      end else begin
         len = cap_ff;
      end

      case (q_item.kind)
         KIND_FRAME_DONE: begin
            if (prefill_ff != PREFILL_DONE) begin
               stored_in[prefill_ff[0]] = q_item.size;
               wb_in                    = prefill_ff[0];
               prefill_in               = prefill_ff + 2'd1;
               result.frame_accepted    = 1'b1;
            end else if (rb_ff == wb_ff) begin
               wb_in                 = ~wb_ff;
               stored_in[~wb_ff]     = q_item.size;
               result.frame_accepted = 1'b1;
            end
         end
         KIND_PACKET_REQ: begin
            if (cur_size != '0) begin
               flag_in = flag_cur;
               if (frame_end) begin
                  flag_in[FLAG_EOF] = 1'b1;
               end
               result.packet_valid  = 1'b1;
               result.header_flags  = flag_in;
               result.payload_len   = len;
               result.frame_offset  = sent_ff;
               result.buffer_sel    = rb_ff;
               result.endpoint_half = ~half_ff;
               half_in              = ~half_ff;
               if (frame_end) begin
                  sent_in = '0;
                  // move on only to a newer frame that holds data
                  if ((rb_ff != wb_ff) && (stored_ff[wb_ff] != '0)) begin
                     rb_in = wb_ff;
                  end
               end else begin
                  sent_in = span[SIZE_W-1:0];
               end
            end
         end
         default: begin
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= PACKET_BYTES_RESET - HDR_BYTES;
         rb_ff        <= 1'b0;
         wb_ff        <= 1'b0;
         stored_ff[0] <= '0;
         stored_ff[1] <= '0;
         sent_ff      <= '0;
         flag_ff      <= '0;
         half_ff      <= 1'b0;
         prefill_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            rb_ff        <= rb_in;
            wb_ff        <= wb_in;
            stored_ff[0] <= stored_in[0];
            stored_ff[1] <= stored_in[1];
            sent_ff      <= sent_in;
            flag_ff      <= flag_in;
            half_ff      <= half_in;
            prefill_ff   <= prefill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/uvc_pingpong_frame_packetizer.sv =====
// uvc_pingpong_frame_packetizer: top level, front classifier, queue and back end
// depends on upfp_pkg, upfp_front, upfp_queue, upfp_back
`default_nettype none

// Takes one word per cycle while the queue is not full and gives one result word per
// input word, in order. A word is either a frame-done report (tuser 0, frame size in
// tdata) or a packet request (tuser 1). The front clamps the size and pushes the word
// into a queue of QUEUE_DEPTH entries; the back end updates the ping-pong buffer state
// and loads the result register, one word per cycle unless the result port stalls. A
// result passes through a queue entry and the result register; the queue absorbs short
// stalls on the result side. The packet size register is written through the csr
// port, which is always ready, and must only be written while no word is in flight.

module uvc_pingpong_frame_packetizer
   import upfp_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // tdata: frame_bytes[19:0], zero pad[23:20]
   input  wire logic [23:0] req_tdata,
   // tuser: kind[0]
   input  wire logic        req_tuser,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: header_flags[1:0], payload_len[11:2], frame_offset[31:12],
   //        buffer_sel[32], endpoint_half[33], zero pad[39:34]
   output logic [39:0]      rsp_tdata,
   // tuser: frame_accepted[0], packet_valid[1]
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [9:0]  csr_wdata
);

   item_type front_item;
   item_type head_item;
   logic     q_full;
   logic     q_not_empty;
   logic     q_pop;
   logic     push;
   rsp_type  rsp;

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;
   assign csr_ready  = 1'b1;

   upfp_front u_front (
      .req_kind        (req_tuser),
      .req_frame_bytes (req_tdata[SIZE_W-1:0]),
      .item            (front_item)
   );

   upfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   upfp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_wdata   (csr_wdata),
      .q_not_empty (q_not_empty),
      .q_item      (head_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp)
   );

   assign rsp_tuser = {rsp.packet_valid, rsp.frame_accepted};
   assign rsp_tdata = {6'b0, rsp.endpoint_half, rsp.buffer_sel, rsp.frame_offset,
                       rsp.payload_len, rsp.header_flags};

endmodule

`default_nettype wire
